FILE: design/sep_pkg.sv
// ----------------------------------------------------------------------------
// sep_pkg
// Shared types and constants for the SysEx event packetizer.
// ----------------------------------------------------------------------------
package sep_pkg;

    localparam logic [7:0] SYX_START = 8'hF0;
    localparam logic [7:0] SYX_END   = 8'hF7;

    localparam logic [3:0] CIN_CONT     = 4'd4;
    localparam logic [3:0] CIN_END_BASE = 4'd4;
    localparam logic [3:0] CIN_NONE     = 4'd0;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PORT_IS_OUTPUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPTS_LOCAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CABLE_NUMBER   = 2'd2;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_NOT_OUTPUT = 3'd1,
        STS_NOT_LOCAL  = 3'd2,
        STS_BAD_DATA   = 3'd3,
        STS_MISSING_F7 = 3'd4,
        STS_TOO_LONG   = 3'd5
    } t_sep_status;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CHECK,
        ST_EMIT
    } t_sep_state;

    // controller -> datapath
    typedef struct packed {
        logic load;   // take input transactions into the buffer
        logic check;  // load the error result into the output register
        logic emit;   // walk the stream and build packets
        logic clear;  // message finished, empty the buffer
    } t_sep_cmd;

    // datapath -> controller
    typedef struct packed {
        logic err;        // checked message is rejected
        logic out_free;   // output register can take a result this cycle
        logic emit_done;  // final packet loaded this cycle
    } t_sep_sts;

endpackage

FILE: design/sep_ram.sv
// ----------------------------------------------------------------------------
// sep_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/sep_datapath.sv
// ----------------------------------------------------------------------------
// sep_datapath
// Message buffer, running checks, stream walk, packet build and output stage.
// ----------------------------------------------------------------------------
module sep_datapath #(
    parameter int MAX_BYTES = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sep_pkg::t_sep_cmd             i_cmd,
    output sep_pkg::t_sep_sts             o_sts,
    input  logic                          i_cfg_valid,
    input  logic [sep_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sep_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_in_has_byte,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [3:0]                    o_cable,
    output logic [3:0]                    o_code_index,
    output logic [7:0]                    o_byte_zero,
    output logic [7:0]                    o_byte_one,
    output logic [7:0]                    o_byte_two,
    output logic [1:0]                    o_byte_count,
    output logic                          o_final,
    output logic [2:0]                    o_status
);

    localparam int AW = $clog2(MAX_BYTES);
    localparam int CW = $clog2(MAX_BYTES + 1);
    localparam int PW = $clog2(MAX_BYTES + 3);

    // configuration
    logic       r_port_out;
    logic       r_local;
    logic [3:0] r_cable;

    // buffer bookkeeping
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [7:0]    r_first;
    logic [7:0]    r_lastb;
    logic          r_prev_hi;
    logic          r_bad_any;
    logic          r_bad_inner;

    // stream walk
    logic [PW-1:0] r_pos;
    logic [CW-1:0] r_mem_idx;
    logic [1:0]    r_slot;
    logic [7:0]    r_b0;
    logic [7:0]    r_b1;

    // output stage
    logic       r_out_valid;
    logic [3:0] r_out_cin;
    logic [7:0] r_out_b0;
    logic [7:0] r_out_b1;
    logic [7:0] r_out_b2;
    logic [1:0] r_out_cnt;
    logic       r_out_final;
    logic [2:0] r_out_status;

    logic                 wr_byte;
    logic                 wrap;
    logic [PW-1:0]        total;
    sep_pkg::t_sep_status status;
    logic                 out_free;
    logic                 final_byte;
    logic                 is_f0;
    logic                 is_f7;
    logic [7:0]           cur_byte;
    logic                 pkt_complete;
    logic                 advance;
    logic                 consume_mem;
    logic [CW-1:0]        next_idx;
    logic [AW-1:0]        raddr;
    logic [7:0]           rdata;
    logic [1:0]           pkt_cnt;

    assign wr_byte = i_cmd.load && i_in_valid && i_in_has_byte && (r_count < CW'(MAX_BYTES));

    sep_ram #(
        .WIDTH(8),
        .DEPTH(MAX_BYTES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (wr_byte),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_in_byte),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // message check
    assign wrap  = (r_count == '0) || (r_first != sep_pkg::SYX_START);
    assign total = wrap ? (PW'(r_count) + PW'(2)) : PW'(r_count);

    always_comb begin
        if (!r_port_out) begin
            status = sep_pkg::STS_NOT_OUTPUT;
        end else if (!r_local) begin
            status = sep_pkg::STS_NOT_LOCAL;
        end else if (r_ovf) begin
            status = sep_pkg::STS_TOO_LONG;
        end else if (!wrap && ((r_lastb != sep_pkg::SYX_END) || (r_count < CW'(2)))) begin
            status = sep_pkg::STS_MISSING_F7;
        end else if (wrap ? r_bad_any : r_bad_inner) begin
            status = sep_pkg::STS_BAD_DATA;
        end else begin
            status = sep_pkg::STS_OK;
        end
    end

    // stream walk
    assign out_free     = !r_out_valid || i_out_ready;
    assign final_byte   = (r_pos == total - PW'(1));
    assign is_f0        = wrap && (r_pos == '0);
    assign is_f7        = wrap && final_byte;
    assign cur_byte     = is_f0 ? sep_pkg::SYX_START : (is_f7 ? sep_pkg::SYX_END : rdata);
    assign pkt_complete = (r_slot == 2'd2) || final_byte;
    assign advance      = i_cmd.emit && (!pkt_complete || out_free);
    assign consume_mem  = advance && !is_f0 && !is_f7;
    assign next_idx     = consume_mem ? (r_mem_idx + CW'(1)) : r_mem_idx;
    assign raddr        = (next_idx < CW'(MAX_BYTES)) ? next_idx[AW-1:0] : '0;
    assign pkt_cnt      = r_slot + 2'd1;

    assign o_sts.err       = (status != sep_pkg::STS_OK);
    assign o_sts.out_free  = out_free;
    assign o_sts.emit_done = i_cmd.emit && final_byte && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_out <= 1'b0;
            r_local    <= 1'b0;
            r_cable    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sep_pkg::CFG_PORT_IS_OUTPUT: r_port_out <= i_cfg_data[0];
                sep_pkg::CFG_ACCEPTS_LOCAL:  r_local    <= i_cfg_data[0];
                sep_pkg::CFG_CABLE_NUMBER:   r_cable    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_bad_any   <= 1'b0;
            r_bad_inner <= 1'b0;
            r_prev_hi   <= 1'b0;
            r_pos       <= '0;
            r_mem_idx   <= '0;
            r_slot      <= '0;
        end else begin
            if (i_cmd.load && i_in_valid && i_in_has_byte) begin
                if (wr_byte) begin
                    r_count   <= r_count + CW'(1);
                    r_bad_any <= r_bad_any | i_in_byte[7];
                    if (r_count >= CW'(2)) begin
                        r_bad_inner <= r_bad_inner | r_prev_hi;
                    end
                    r_prev_hi <= i_in_byte[7];
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (advance) begin
                r_pos     <= r_pos + PW'(1);
                r_mem_idx <= next_idx;
                r_slot    <= pkt_complete ? 2'd0 : r_slot + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_byte) begin
            if (r_count == '0) begin
                r_first <= i_in_byte;
            end
            r_lastb <= i_in_byte;
        end
        if (advance) begin
            if (r_slot == 2'd0) begin
                r_b0 <= cur_byte;
                r_b1 <= '0;
            end else if (r_slot == 2'd1) begin
                r_b1 <= cur_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.check || (advance && pkt_complete)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_out_cin    <= sep_pkg::CIN_NONE;
            r_out_b0     <= '0;
            r_out_b1     <= '0;
            r_out_b2     <= '0;
            r_out_cnt    <= '0;
            r_out_final  <= 1'b1;
            r_out_status <= status;
        end else if (advance && pkt_complete) begin
            r_out_cin    <= final_byte ? (sep_pkg::CIN_END_BASE + {2'b00, pkt_cnt})
                                       : sep_pkg::CIN_CONT;
            r_out_b0     <= (r_slot == 2'd0) ? cur_byte : r_b0;
            r_out_b1     <= (r_slot == 2'd1) ? cur_byte : ((r_slot == 2'd0) ? 8'h00 : r_b1);
            r_out_b2     <= (r_slot == 2'd2) ? cur_byte : 8'h00;
            r_out_cnt    <= pkt_cnt;
            r_out_final  <= final_byte;
            r_out_status <= sep_pkg::STS_OK;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cable      = r_cable;
    assign o_code_index = r_out_cin;
    assign o_byte_zero  = r_out_b0;
    assign o_byte_one   = r_out_b1;
    assign o_byte_two   = r_out_b2;
    assign o_byte_count = r_out_cnt;
    assign o_final      = r_out_final;
    assign o_status     = r_out_status;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BYTES))
        else $error("byte count beyond buffer depth");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CW'(MAX_BYTES)))
        else $error("overflow flagged with room left");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_pos < total))
        else $error("stream position past end of message");

    a_err_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != sep_pkg::STS_OK)) |-> r_out_final)
        else $error("error result not marked final");

endmodule

FILE: design/sep_ctrl.sv
// ----------------------------------------------------------------------------
// sep_ctrl
// Sequencer: load, check, then packet emission or an error result.
// ----------------------------------------------------------------------------
module sep_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    input  sep_pkg::t_sep_sts i_sts,
    output sep_pkg::t_sep_cmd o_cmd
);

    sep_pkg::t_sep_state r_state;
    sep_pkg::t_sep_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sep_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            sep_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_in_valid && i_in_last) begin
                    n_state = sep_pkg::ST_CHECK;
                end
            end
            sep_pkg::ST_CHECK: begin
                if (!i_sts.err) begin
                    n_state = sep_pkg::ST_EMIT;
                end else if (i_sts.out_free) begin
                    o_cmd.check = 1'b1;
                    o_cmd.clear = 1'b1;
                    n_state     = sep_pkg::ST_LOAD;
                end
            end
            sep_pkg::ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.emit_done) begin
                    o_cmd.clear = 1'b1;
                    n_state     = sep_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = sep_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

FILE: design/sysex_event_packetizer_top.sv
// ----------------------------------------------------------------------------
// sysex_event_packetizer_top
// Packs a loaded SysEx message into USB-MIDI event packets.
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle into a buffer of MAX_BYTES entries
// with one write and one read port. After the transaction marked last the
// block checks the message; a rejected message gives one error result once
// the output register is free. An accepted message is then read back one
// stream byte per cycle while the output side takes packets (the buffer has
// one read port); the block adds F0 and F7 itself when the message does not
// begin with F0. Input is held off from the last byte until the final result
// of the message sits in the output register.
module sysex_event_packetizer_top #(
    parameter int MAX_BYTES = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sep_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sep_pkg::CFG_DAT_W-1:0] i_cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
    input  logic [0:0]                    s_axis_tuser,  // [0] has_byte
    input  logic                          s_axis_tlast,
    // packet stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [3:0] cable, [7:4] code_index, [15:8] byte_zero, [23:16] byte_one,
    // [31:24] byte_two, [33:32] byte_count, [39:34] zero
    output logic [39:0]                   m_axis_tdata,
    output logic [2:0]                    m_axis_tuser,  // [2:0] status
    output logic                          m_axis_tlast
);

    sep_pkg::t_sep_cmd cmd;
    sep_pkg::t_sep_sts sts;

    logic [3:0] cable;
    logic [3:0] code_index;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [1:0] byte_count;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = cmd.load;

    sep_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .i_in_last (s_axis_tlast),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    sep_datapath #(
        .MAX_BYTES(MAX_BYTES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_byte    (s_axis_tdata),
        .i_in_has_byte(s_axis_tuser[0]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_cable      (cable),
        .o_code_index (code_index),
        .o_byte_zero  (byte_zero),
        .o_byte_one   (byte_one),
        .o_byte_two   (byte_two),
        .o_byte_count (byte_count),
        .o_final      (m_axis_tlast),
        .o_status     (m_axis_tuser)
    );

    assign m_axis_tdata = {6'b000000, byte_count, byte_two, byte_one, byte_zero,
                           code_index, cable};

endmodule
